@@ sv/brca_pkg.sv @@
// Shared types and constants for the banked RAM with common area.
// No dependencies; used by the request/response interfaces and the top level.
`default_nettype none

package brca_pkg;

    // Storage geometry
    localparam int MAX_BANKS      = 8;
    localparam int MAX_BANK_BYTES = 65536;
    localparam int BANK_W         = 3;
    localparam int OFFSET_W       = 16;
    localparam int MEM_ADDR_W     = BANK_W + OFFSET_W;
    localparam int MEM_DEPTH      = MAX_BANKS * MAX_BANK_BYTES;

    // Field widths
    localparam int ADDR_W       = 16;
    localparam int DATA_W       = 8;
    localparam int SIZE_W       = 17;
    localparam int BANK_CNT_W   = 4;

    // Bank select port
    localparam logic [ADDR_W-1:0] BANK_PORT = 16'h00F0;

    // APB register map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_WINDOW_BASE   = 2'd0;
    localparam logic [1:0] REG_COMMON_OFFSET = 2'd1;
    localparam logic [1:0] REG_BANK_BYTES    = 2'd2;
    localparam logic [1:0] REG_BANKS_PRESENT = 2'd3;

    // Register reset values
    localparam logic [ADDR_W-1:0]     WINDOW_BASE_RST   = 16'h0000;
    localparam logic [ADDR_W-1:0]     COMMON_OFFSET_RST = 16'hFFFF;
    localparam logic [SIZE_W-1:0]     BANK_BYTES_RST    = 17'h10000;
    localparam logic [BANK_CNT_W-1:0] BANKS_PRESENT_RST = 4'd1;

    typedef enum logic [1:0] {
        OP_MEM_READ   = 2'd0,
        OP_MEM_WRITE  = 2'd1,
        OP_PORT_READ  = 2'd2,
        OP_PORT_WRITE = 2'd3
    } op_t;

endpackage

`default_nettype wire

@@ sv/brca_if.sv @@
// Valid/ready channel interfaces for bus requests and their responses.
// Depends on brca_pkg for the operation type and field widths.
`default_nettype none

interface brca_req_if;
    logic                               valid;
    logic                               ready;
    brca_pkg::op_t                      operation;
    logic [brca_pkg::ADDR_W-1:0]        address;
    logic [brca_pkg::DATA_W-1:0]        write_data;

    modport source (output valid, operation, address, write_data, input ready);
    modport sink   (input valid, operation, address, write_data, output ready);
endinterface

interface brca_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               selected;
    logic [brca_pkg::DATA_W-1:0]        read_data;
    logic                               bank_rejected;

    modport source (output valid, selected, read_data, bank_rejected, input ready);
    modport sink   (input valid, selected, read_data, bank_rejected, output ready);
endinterface

`default_nettype wire

@@ sv/banked_ram_with_common_area.sv @@
// Banked RAM with common area: sustains one bus request per cycle while the
// response side is not stalled by rsp.ready. Each response passes through the
// synchronous read of the 8 x 64 KiB byte memory, then the response register.
// rst_n (async, active low) clears the active bank and pipeline valids and resets
// the config registers; memory contents are undefined until written, with no clearing pass.
// Depends on brca_pkg and the interfaces in brca_if.sv.
`default_nettype none

module banked_ram_with_common_area (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // APB config port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [brca_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [brca_pkg::PDATA_W-1:0]    pwdata,
    output      logic [brca_pkg::PDATA_W-1:0]    prdata,
    output      logic                            pready,
    // Request and response channels
    brca_req_if.sink                             req,
    brca_rsp_if.source                           rsp
);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [brca_pkg::ADDR_W-1:0]     window_base_reg;
    logic [brca_pkg::ADDR_W-1:0]     common_offset_reg;
    logic [brca_pkg::SIZE_W-1:0]     bank_bytes_reg;
    logic [brca_pkg::BANK_CNT_W-1:0] banks_present_reg;

    logic       cfg_wr;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_base_reg   <= brca_pkg::WINDOW_BASE_RST;
            common_offset_reg <= brca_pkg::COMMON_OFFSET_RST;
            bank_bytes_reg    <= brca_pkg::BANK_BYTES_RST;
            banks_present_reg <= brca_pkg::BANKS_PRESENT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                brca_pkg::REG_WINDOW_BASE:   window_base_reg   <= pwdata[15:0];
                brca_pkg::REG_COMMON_OFFSET: common_offset_reg <= pwdata[15:0];
                brca_pkg::REG_BANK_BYTES:    bank_bytes_reg    <= pwdata[16:0];
                brca_pkg::REG_BANKS_PRESENT: banks_present_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            brca_pkg::REG_WINDOW_BASE:   prdata = {16'd0, window_base_reg};
            brca_pkg::REG_COMMON_OFFSET: prdata = {16'd0, common_offset_reg};
            brca_pkg::REG_BANK_BYTES:    prdata = {15'd0, bank_bytes_reg};
            brca_pkg::REG_BANKS_PRESENT: prdata = {28'd0, banks_present_reg};
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake / pipeline control
    //   stage 1: memory read in flight (or port result waiting)
    //   output:  registered response
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic rsp_valid_reg;
    logic out_load;
    logic req_fire;

    assign out_load  = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || out_load;
    assign req_fire  = req.valid && req.ready;
    assign rsp.valid = rsp_valid_reg;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic [brca_pkg::SIZE_W-1:0]     win_size;
    logic [brca_pkg::BANK_CNT_W-1:0] bank_limit;
    logic [brca_pkg::OFFSET_W-1:0]   offset;
    logic                            in_window;
    logic                            is_mem;
    logic                            is_port;
    logic [brca_pkg::BANK_W-1:0]     eff_bank;
    logic [brca_pkg::MEM_ADDR_W-1:0] mem_addr;
    logic                            mem_we;
    logic                            mem_re;
    logic                            bank_bad;
    logic [brca_pkg::BANK_W-1:0]     active_bank_reg;

    // Oversized settings saturate to the physical geometry
    assign win_size = (bank_bytes_reg > brca_pkg::SIZE_W'(brca_pkg::MAX_BANK_BYTES))
                      ? brca_pkg::SIZE_W'(brca_pkg::MAX_BANK_BYTES) : bank_bytes_reg;
    assign bank_limit = (banks_present_reg > brca_pkg::BANK_CNT_W'(brca_pkg::MAX_BANKS))
                        ? brca_pkg::BANK_CNT_W'(brca_pkg::MAX_BANKS) : banks_present_reg;

    // Strict window bound; window does not wrap past 0xFFFF
    assign offset    = req.address - window_base_reg;
    assign in_window = (req.address >= window_base_reg)
                       && ({1'b0, offset} < win_size);

    assign is_mem  = (req.operation == brca_pkg::OP_MEM_READ)
                     || (req.operation == brca_pkg::OP_MEM_WRITE);
    assign is_port = !is_mem && (req.address == brca_pkg::BANK_PORT);

    // Common area always maps to bank 0
    assign eff_bank = (offset >= common_offset_reg) ? '0 : active_bank_reg;
    assign mem_addr = {eff_bank, offset};

    assign mem_we = req_fire && in_window && (req.operation == brca_pkg::OP_MEM_WRITE);
    assign mem_re = req_fire && in_window && (req.operation == brca_pkg::OP_MEM_READ);

    assign bank_bad = req.write_data >= {4'd0, bank_limit};

    // ------------------------------------------------------------------
    // Active bank register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_bank_reg <= '0;
        end
        else if (req_fire && is_port && (req.operation == brca_pkg::OP_PORT_WRITE))
        begin
            active_bank_reg <= bank_bad ? '0 : req.write_data[brca_pkg::BANK_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Byte store: one port, read data registered. A request only reads or
    // writes, and a later request reads after an earlier write has landed, so no forwarding.
    // ------------------------------------------------------------------
    logic [brca_pkg::DATA_W-1:0] mem [brca_pkg::MEM_DEPTH];
    logic [brca_pkg::DATA_W-1:0] mem_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= req.write_data;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 payload
    // ------------------------------------------------------------------
    logic                        s1_sel_reg;
    logic                        s1_mem_rd_reg;
    logic [brca_pkg::DATA_W-1:0] s1_data_reg;
    logic                        s1_rej_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_sel_reg    <= is_mem ? in_window : is_port;
            s1_mem_rd_reg <= mem_re;
            // port read returns the bank in effect before this request
            s1_data_reg   <= (is_port && (req.operation == brca_pkg::OP_PORT_READ))
                             ? {5'd0, active_bank_reg} : '0;
            s1_rej_reg    <= is_port && (req.operation == brca_pkg::OP_PORT_WRITE)
                             && bank_bad;
        end
    end

    // ------------------------------------------------------------------
    // Response register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rsp.selected      <= s1_sel_reg;
            rsp.read_data     <= s1_mem_rd_reg ? mem_rdata_reg : s1_data_reg;
            rsp.bank_rejected <= s1_rej_reg;
        end
    end

endmodule

`default_nettype wire
